FILE: hdl/imu_serial_frame_parser_assert.svh
// Assertion macros for the IMU serial frame parser.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef IMU_SERIAL_FRAME_PARSER_ASSERT_SVH
`define IMU_SERIAL_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/imu_sfp_pkg.sv
// Shared constants and types for the IMU serial frame parser.
// No dependencies; imported by all RTL modules, checker and testbench.
package imu_sfp_pkg;

    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] TYPE_LOW   = 8'h50;
    localparam logic [7:0] TYPE_HIGH  = 8'h5A;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;
    localparam logic [7:0] TYPE_QUAT  = 8'h59;

    localparam int FRAME_LEN    = 11;
    localparam int POS_W        = 4;
    localparam int DATA_BYTES   = 8;
    localparam int DATA_IDX_W   = 3;
    localparam int NUM_CHANNELS = 13;
    localparam int CHAN_W       = 4;
    localparam int SAMPLE_W     = 16;
    localparam int TIME_W       = 32;

    localparam logic [POS_W-1:0]  POS_TYPE     = POS_W'(1);
    localparam logic [POS_W-1:0]  POS_FIRST    = POS_W'(2);
    localparam logic [POS_W-1:0]  POS_CHECKSUM = POS_W'(FRAME_LEN - 1);
    localparam logic [CHAN_W-1:0] LAST_CHANNEL = CHAN_W'(NUM_CHANNELS - 1);

    typedef logic [NUM_CHANNELS-1:0][SAMPLE_W-1:0] chan_vals_t;

    typedef struct packed {
        logic              fire;
        logic [TIME_W-1:0] stamp;
    } snap_req_t;

endpackage

FILE: hdl/imu_sfp_parser.sv
// Byte-level frame parser: sync hunt, type check, running checksum, value registers.
// Depends on imu_sfp_pkg.
module imu_sfp_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           kind,
    input  logic [7:0]                     rx_byte,
    input  logic [31:0]                    now_ms,
    output logic [imu_sfp_pkg::POS_W-1:0]  frame_pos,
    output imu_sfp_pkg::snap_req_t         snap_req,
    output imu_sfp_pkg::chan_vals_t        snap_vals
);
    import imu_sfp_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        type_reg, type_next;
    logic [7:0]        data_reg [DATA_BYTES];
    logic              data_we;
    logic [DATA_IDX_W-1:0] data_idx;
    chan_vals_t        vals_reg, vals_next;
    logic              have_accel_reg, have_accel_next;
    logic              have_rate_reg, have_rate_next;
    logic              fire;
    logic [SAMPLE_W-1:0] words [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            words[k] = {data_reg[2*k+1], data_reg[2*k]};
        end
    end

    assign data_idx = DATA_IDX_W'(pos_reg - POS_FIRST);

    always_comb
    begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        type_next       = type_reg;
        vals_next       = vals_reg;
        have_accel_next = have_accel_reg;
        have_rate_next  = have_rate_reg;
        data_we         = 1'b0;
        fire            = 1'b0;
        if (accept)
        begin
            if (kind)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else if (pos_reg == '0)
            begin
                if (rx_byte == SYNC_BYTE)
                begin
                    sum_next = rx_byte;
                    pos_next = POS_TYPE;
                end
            end
            else if (pos_reg == POS_TYPE)
            begin
                if (rx_byte < TYPE_LOW || rx_byte > TYPE_HIGH)
                begin
                    pos_next = '0;
                    sum_next = '0;
                end
                else
                begin
                    type_next = rx_byte;
                    sum_next  = sum_reg + rx_byte;
                    pos_next  = POS_FIRST;
                end
            end
            else if (pos_reg < POS_CHECKSUM)
            begin
                data_we  = 1'b1;
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + POS_W'(1);
            end
            else
            begin
                // checksum byte: drop the frame on mismatch
                pos_next = '0;
                sum_next = '0;
                if (sum_reg == rx_byte)
                begin
                    case (type_reg)
                        TYPE_ACCEL:
                        begin
                            for (int k = 0; k < 3; k++) vals_next[k] = words[k];
                            have_accel_next = 1'b1;
                        end
                        TYPE_RATE:
                        begin
                            for (int k = 0; k < 3; k++) vals_next[3+k] = words[k];
                            have_rate_next = 1'b1;
                        end
                        TYPE_ANGLE:
                        begin
                            for (int k = 0; k < 3; k++) vals_next[6+k] = words[k];
                            fire = have_accel_reg && have_rate_reg;
                        end
                        TYPE_QUAT:
                        begin
                            for (int k = 0; k < 4; k++) vals_next[9+k] = words[k];
                        end
                        default:
                        begin
                            fire = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            sum_reg        <= '0;
            vals_reg       <= '0;
            have_accel_reg <= 1'b0;
            have_rate_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            vals_reg       <= vals_next;
            have_accel_reg <= have_accel_next;
            have_rate_reg  <= have_rate_next;
        end
    end

    // frame payload needs no reset: only bytes of the current frame are read
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        if (data_we)
        begin
            data_reg[data_idx] <= rx_byte;
        end
    end

    assign frame_pos      = pos_reg;
    assign snap_req.fire  = fire;
    assign snap_req.stamp = now_ms;
    assign snap_vals      = vals_next;

endmodule

FILE: hdl/imu_sfp_emitter.sv
// Snapshot buffer and output register: plays out 13 channel beats per snapshot.
// Depends on imu_sfp_pkg.
module imu_sfp_emitter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  imu_sfp_pkg::snap_req_t           snap_req,
    input  imu_sfp_pkg::chan_vals_t          snap_vals,
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [imu_sfp_pkg::CHAN_W-1:0]   channel,
    output logic signed [15:0]               sample,
    output logic [31:0]                      timestamp_ms,
    output logic                             last
);
    import imu_sfp_pkg::*;

    chan_vals_t          buf_reg;
    logic [TIME_W-1:0]   stamp_reg;
    logic [CHAN_W-1:0]   idx_reg;
    logic                busy_reg;
    logic                valid_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]   ts_reg;
    logic                last_reg;
    logic                load;

    // advance when the output register is empty or being taken
    assign load = busy_reg && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_req.fire)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + CHAN_W'(1);
                if (idx_reg == LAST_CHANNEL)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_req.fire)
        begin
            buf_reg   <= snap_vals;
            stamp_reg <= snap_req.stamp;
        end
        if (load)
        begin
            chan_reg   <= idx_reg;
            sample_reg <= buf_reg[idx_reg];
            ts_reg     <= stamp_reg;
            last_reg   <= (idx_reg == LAST_CHANNEL);
        end
    end

    assign busy         = busy_reg;
    assign out_valid    = valid_reg;
    assign channel      = chan_reg;
    assign sample       = $signed(sample_reg);
    assign timestamp_ms = ts_reg;
    assign last         = last_reg;

endmodule

FILE: hdl/imu_serial_frame_parser.sv
// Top level of the IMU serial frame parser: byte parser feeding a snapshot emitter.
// Depends on imu_sfp_pkg, imu_sfp_parser, imu_sfp_emitter and the assertion header.
//
//   Channel  Direction  Handshake            Beat contents
//   in       sink       in_valid / in_stall  kind, rx_byte, now_ms
//   out      source     out_valid / out_stall channel, sample, timestamp_ms, last
//
// One byte is taken per unstalled cycle; its frame state updates at the accepting edge.
// A good angle frame with both accel and rate seen yields 13 beats via the snapshot
// buffer and the output register, one per cycle the output is not stalled.
// in_stall rises only while a snapshot is still playing out and the next byte
// would be a checksum byte; it is set by the single snapshot buffer.
// Reset (rst_n, asynchronous) clears frame position, checksum, values and flags.
module imu_serial_frame_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic [7:0]                      rx_byte,
    input  logic [31:0]                     now_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [imu_sfp_pkg::CHAN_W-1:0]  channel,
    output logic signed [15:0]              sample,
    output logic [31:0]                     timestamp_ms,
    output logic                            last
);
    import imu_sfp_pkg::*;

`include "imu_serial_frame_parser_assert.svh"

    logic             in_accept;
    logic [POS_W-1:0] frame_pos;
    logic             emit_busy;
    snap_req_t        snap_req;
    chan_vals_t       snap_vals;

    // hold input only when a new snapshot could collide with one in flight
    assign in_stall  = emit_busy && (frame_pos == POS_CHECKSUM);
    assign in_accept = in_valid && !in_stall;

    imu_sfp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .kind      (kind),
        .rx_byte   (rx_byte),
        .now_ms    (now_ms),
        .frame_pos (frame_pos),
        .snap_req  (snap_req),
        .snap_vals (snap_vals)
    );

    imu_sfp_emitter u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_req     (snap_req),
        .snap_vals    (snap_vals),
        .busy         (emit_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .channel      (channel),
        .sample       (sample),
        .timestamp_ms (timestamp_ms),
        .last         (last)
    );

    // a snapshot must never overwrite one still playing out
    `SFP_ASSERT_NOW(a_no_fire_while_busy, snap_req.fire, !emit_busy, "snapshot while busy")
    // a fired snapshot starts playing out on the next cycle
    `SFP_ASSERT_NEXT(a_fire_starts_run, snap_req.fire, emit_busy, "snapshot not started")
    // the end-of-run flag belongs to the final channel only
    `SFP_ASSERT_NOW(a_last_on_final, out_valid && last, channel == LAST_CHANNEL,
        "last on wrong channel")

endmodule

FILE: tb/imu_serial_frame_parser_checker.sv
// Checker for the IMU serial frame parser: watches both channels, predicts snapshot beats.
// Depends on imu_sfp_pkg for frame constants and field widths.
module imu_serial_frame_parser_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             kind,
    input  logic [7:0]                       rx_byte,
    input  logic [31:0]                      now_ms,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [imu_sfp_pkg::CHAN_W-1:0]   channel,
    input  logic signed [15:0]               sample,
    input  logic [31:0]                      timestamp_ms,
    input  logic                             last,
    output int                               mismatch_count,
    output int                               outstanding
);
    import imu_sfp_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] smp;
        logic [TIME_W-1:0]   stamp;
        logic                lst;
    } snap_beat_t;

    snap_beat_t          snapshot_q[$];

    logic [POS_W-1:0]    frame_pos;
    logic [7:0]          frame_buf [0:FRAME_LEN-1];
    logic [7:0]          byte_sum;
    logic [SAMPLE_W-1:0] latest [0:NUM_CHANNELS-1];
    logic                seen_accel;
    logic                seen_rate;

    // Copy little-endian words from the data bytes into the latest values.
    task automatic load_words(input int first, input int count);
        int i;
        begin
            for (i = 0; i < count; i++)
                latest[first + i] = {frame_buf[3 + 2 * i], frame_buf[2 + 2 * i]};
        end
    endtask

    // Advance the frame state by one input beat; queue a snapshot on a good angle frame.
    task automatic absorb_beat(input logic is_resync, input logic [7:0] b,
                               input logic [31:0] t);
        logic [7:0] ftype;
        snap_beat_t e;
        int         c;
        begin
            if (is_resync)
            begin
                frame_pos = '0;
                byte_sum  = '0;
            end
            else if (frame_pos == '0)
            begin
                if (b == SYNC_BYTE)
                begin
                    frame_buf[0] = b;
                    byte_sum     = b;
                    frame_pos    = POS_TYPE;
                end
            end
            else if (frame_pos == POS_TYPE)
            begin
                if (b < TYPE_LOW || b > TYPE_HIGH)
                begin
                    frame_pos = '0;
                    byte_sum  = '0;
                end
                else
                begin
                    frame_buf[1] = b;
                    byte_sum     = byte_sum + b;
                    frame_pos    = POS_FIRST;
                end
            end
            else if (frame_pos < POS_CHECKSUM)
            begin
                frame_buf[frame_pos] = b;
                byte_sum  = byte_sum + b;
                frame_pos = frame_pos + 1'b1;
            end
            else
            begin
                frame_buf[FRAME_LEN - 1] = b;
                frame_pos = '0;
                if (byte_sum == b)
                begin
                    ftype = frame_buf[1];
                    case (ftype)
                        TYPE_ACCEL:
                        begin
                            load_words(0, 3);
                            seen_accel = 1'b1;
                        end
                        TYPE_RATE:
                        begin
                            load_words(3, 3);
                            seen_rate = 1'b1;
                        end
                        TYPE_ANGLE: load_words(6, 3);
                        TYPE_QUAT:  load_words(9, 4);
                        default:    ;
                    endcase
                    if (ftype == TYPE_ANGLE && seen_accel && seen_rate)
                    begin
                        for (c = 0; c < NUM_CHANNELS; c++)
                        begin
                            e.chan  = CHAN_W'(c);
                            e.smp   = latest[c];
                            e.stamp = t;
                            e.lst   = (CHAN_W'(c) == LAST_CHANNEL);
                            snapshot_q.push_back(e);
                        end
                    end
                end
                byte_sum = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        snap_beat_t want;
        int         c;
        if (!rst_n)
        begin
            frame_pos      = '0;
            byte_sum       = '0;
            seen_accel     = 1'b0;
            seen_rate      = 1'b0;
            mismatch_count = 0;
            for (c = 0; c < NUM_CHANNELS; c++)
                latest[c] = '0;
            snapshot_q.delete();
            outstanding    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (snapshot_q.size() == 0)
                begin
                    $error("unexpected output beat: channel %0d sample %0d", channel, sample);
                    mismatch_count++;
                end
                else
                begin
                    want = snapshot_q.pop_front();
                    if (channel !== want.chan)
                    begin
                        $error("channel: expected %0d, got %0d", want.chan, channel);
                        mismatch_count++;
                    end
                    if (sample !== want.smp)
                    begin
                        $error("sample: expected %0d, got %0d", $signed(want.smp), sample);
                        mismatch_count++;
                    end
                    if (timestamp_ms !== want.stamp)
                    begin
                        $error("timestamp_ms: expected %0h, got %0h", want.stamp, timestamp_ms);
                        mismatch_count++;
                    end
                    if (last !== want.lst)
                    begin
                        $error("last: expected %0b, got %0b", want.lst, last);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_beat(kind, rx_byte, now_ms);
            outstanding = snapshot_q.size();
        end
    end

endmodule

FILE: tb/imu_serial_frame_parser_tb.sv
// Testbench top for the IMU serial frame parser: drives byte streams and gives the verdict.
// Depends on imu_sfp_pkg, the parser RTL and imu_serial_frame_parser_checker.
module imu_serial_frame_parser_tb;
    import imu_sfp_pkg::*;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_RESYNC = 1'b1;

    localparam int RANDOM_BEATS = 200;
    localparam int CALM_FROM    = 260;  // beats between these two counts run with no idling
    localparam int CALM_TO      = 380;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_CUT} frame_flaw_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     kind;
    logic [7:0]               rx_byte;
    logic [31:0]              now_ms;
    logic                     out_valid;
    logic                     out_stall;
    logic [CHAN_W-1:0]        channel;
    logic signed [15:0]       sample;
    logic [31:0]              timestamp_ms;
    logic                     last;

    int                       mismatch_count;
    int                       outstanding;

    // Stimulus bookkeeping, written only by the stimulus process.
    int                       beats;
    logic                     calm;
    logic                     idle_on;
    logic                     hold_req;

    // Written only by the hold-off process.
    logic                     hold_active;

    imu_serial_frame_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .channel      (channel),
        .sample       (sample),
        .timestamp_ms (timestamp_ms),
        .last         (last)
    );

    imu_serial_frame_parser_checker snapshot_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .channel        (channel),
        .sample         (sample),
        .timestamp_ms   (timestamp_ms),
        .last           (last),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive every input to a known value from time zero, starting in reset.
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_BYTE;
        rx_byte   = '0;
        now_ms    = '0;
        out_stall = 1'b0;
    end

    // Receiver: stall at random about a third of the time, and solidly during a hold-off.
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= hold_active || (idle_on && ($urandom_range(0, 99) < 33));
        end
    end

    // Hold-off: once requested, keep the output stalled for a counted stretch so the
    // single snapshot buffer fills and the parser must stall its byte input.
    initial
    begin : hold_off
        int n;
        hold_active = 1'b0;
        wait (hold_req);
        @(negedge clk);
        hold_active <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(negedge clk);
        hold_active <= 1'b0;
    end

    // Watchdog: end the run as failed if the cycle count runs past the limit.
    initial
    begin : watchdog
        int n;
        n = 0;
        while (n < CYCLE_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Offer one beat from a falling edge and hold it until the rising edge that takes it.
    // Drop valid for random cycles first unless this stretch runs without idling.
    task automatic put_beat(input logic k, input logic [7:0] b, input logic [31:0] t);
        logic may_idle;
        begin
            may_idle = !calm && !(beats >= CALM_FROM && beats < CALM_TO);
            idle_on <= may_idle;
            while (may_idle && ($urandom_range(0, 99) < 33))
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            kind     <= k;
            rx_byte  <= b;
            now_ms   <= t;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            beats++;
            @(negedge clk);
        end
    endtask

    // Pick a word, favoring the signed extremes now and then.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0][15:0] pick_words();
        logic [3:0][15:0] w;
        int               j;
        for (j = 0; j < 4; j++)
            w[j] = pick_word();
        return w;
    endfunction

    // Send an 11-byte frame: sync, type, four little-endian words, checksum.
    // A bad-sum flaw corrupts the checksum; a cut flaw stops early and sends a resync.
    // The checksum byte carries the given stamp, which a snapshot will report.
    task automatic send_frame(input logic [7:0] ftype, input logic [3:0][15:0] w,
                              input frame_flaw_t flaw, input logic [31:0] stamp);
        logic [7:0] fb [0:FRAME_LEN-1];
        logic [7:0] sum;
        int         j;
        int         n_bytes;
        begin
            fb[0] = SYNC_BYTE;
            fb[1] = ftype;
            for (j = 0; j < 4; j++)
            begin
                fb[2 + 2 * j] = w[j][7:0];
                fb[3 + 2 * j] = w[j][15:8];
            end
            sum = '0;
            for (j = 0; j < FRAME_LEN - 1; j++)
                sum = sum + fb[j];
            fb[FRAME_LEN - 1] = sum;
            if (flaw == FLAW_SUM)
                fb[FRAME_LEN - 1] = sum ^ 8'($urandom_range(1, 255));
            n_bytes = (flaw == FLAW_CUT) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
            for (j = 0; j < n_bytes; j++)
                put_beat(KIND_BYTE, fb[j], (j == FRAME_LEN - 1) ? stamp : $urandom);
            if (flaw == FLAW_CUT)
                put_beat(KIND_RESYNC, 8'($urandom), $urandom);
        end
    endtask

    // Pick a type for a good frame: mostly the four that load values, some of the rest.
    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22)
            return TYPE_ACCEL;
        if (r < 44)
            return TYPE_RATE;
        if (r < 70)
            return TYPE_ANGLE;
        if (r < 85)
            return TYPE_QUAT;
        case ($urandom_range(0, 3))
            0:       return TYPE_LOW;
            1:       return TYPE_HIGH;
            default: return 8'($urandom_range(TYPE_ANGLE + 1, TYPE_QUAT - 1));
        endcase
    endfunction

    initial
    begin : stimulus
        int start;
        int r;
        int n;
        int j;

        beats      = 0;
        calm       = 1'b0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: junk while hunting, resync carrying a sync byte, time extremes.
        put_beat(KIND_BYTE, 8'h00, 32'h0000_0000);
        put_beat(KIND_BYTE, 8'hFF, 32'hFFFF_FFFF);
        put_beat(KIND_RESYNC, SYNC_BYTE, 32'h0000_0000);

        // Angle frame before either flag: updates angles, emits nothing.
        send_frame(TYPE_ANGLE, {16'h0000, 16'h0000, 16'h8000, 16'h7FFF}, FLAW_NONE,
                   32'hFFFF_FFFF);

        // Type bytes just outside the legal range drop back to hunting.
        put_beat(KIND_BYTE, SYNC_BYTE, $urandom);
        put_beat(KIND_BYTE, TYPE_LOW - 8'd1, $urandom);
        put_beat(KIND_BYTE, SYNC_BYTE, $urandom);
        put_beat(KIND_BYTE, TYPE_HIGH + 8'd1, $urandom);

        // Bad checksum and a frame cut short by resync: both dropped.
        send_frame(TYPE_ACCEL, pick_words(), FLAW_SUM, $urandom);
        send_frame(TYPE_RATE, pick_words(), FLAW_CUT, $urandom);

        // Load every value group, pass both end types of the range, complete two snapshots.
        send_frame(TYPE_ACCEL, {16'h1234, 16'hFFFF, 16'h7FFF, 16'h8000}, FLAW_NONE, $urandom);
        send_frame(TYPE_RATE, {16'hABCD, 16'h0001, 16'h8000, 16'h7FFF}, FLAW_NONE, $urandom);
        send_frame(TYPE_QUAT, {16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000}, FLAW_NONE, $urandom);
        send_frame(TYPE_LOW, pick_words(), FLAW_NONE, $urandom);
        send_frame(TYPE_HIGH, pick_words(), FLAW_NONE, $urandom);
        send_frame(TYPE_ANGLE, {16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF}, FLAW_NONE,
                   32'h0000_0000);
        send_frame(TYPE_ANGLE, pick_words(), FLAW_NONE, 32'hFFFF_FFFF);

        // Pressure: stall the output for a long stretch and keep offering angle frames
        // back to back, so the snapshot buffer fills and the checksum byte is held off.
        calm     = 1'b1;
        hold_req = 1'b1;
        for (j = 0; j < 4; j++)
            send_frame(TYPE_ANGLE, pick_words(), FLAW_NONE, $urandom);
        calm = 1'b0;

        // Random: mostly good frames with random content, the rest broken frames and noise.
        start = beats;
        while ((beats - start) < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(pick_type(), pick_words(), FLAW_NONE, $urandom);
            else if (r < 78)
                send_frame(8'($urandom_range(TYPE_LOW, TYPE_HIGH)), pick_words(), FLAW_SUM,
                           $urandom);
            else if (r < 85)
                send_frame(pick_type(), pick_words(), FLAW_CUT, $urandom);
            else if (r < 92)
            begin
                // Sync followed by an illegal type, then a few stray bytes.
                put_beat(KIND_BYTE, SYNC_BYTE, $urandom);
                if ($urandom_range(0, 1) == 0)
                    put_beat(KIND_BYTE, 8'($urandom_range(0, TYPE_LOW - 1)), $urandom);
                else
                    put_beat(KIND_BYTE, 8'($urandom_range(TYPE_HIGH + 1, 255)), $urandom);
                n = $urandom_range(0, 3);
                for (j = 0; j < n; j++)
                    put_beat(KIND_BYTE, 8'($urandom), $urandom);
            end
            else
            begin
                // Line noise with the odd resync; usually end on a resync to realign.
                n = $urandom_range(1, 6);
                for (j = 0; j < n; j++)
                    put_beat(($urandom_range(0, 4) == 0) ? KIND_RESYNC : KIND_BYTE,
                             8'($urandom), $urandom);
                if ($urandom_range(0, 9) < 7)
                    put_beat(KIND_RESYNC, 8'($urandom), $urandom);
            end
        end

        // Drain: drop valid, wait for every predicted beat, then let the pipe settle.
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/imu_sfp_pkg.sv
hdl/imu_sfp_parser.sv
hdl/imu_sfp_emitter.sv
hdl/imu_serial_frame_parser.sv
tb/imu_serial_frame_parser_checker.sv
tb/imu_serial_frame_parser_tb.sv
